/* rtl/cpd_pkg.sv */
// Shared types and constants for the checksummed packet deframer.
// No dependencies; imported by every rtl module of the block.
package cpd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int TYPE_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
  localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'd85;

  // Accepted packet, handed from the parser to the drain.
  typedef struct packed {
    logic [TYPE_W-1:0] ptype;
    logic [LEN_W-1:0]  len;
    logic              bank;
  } desc_t;

  // Payload buffer write from the parser.
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [LEN_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

endpackage

/* rtl/cpd_front.sv */
// Frame parser: hunts for header, checks length, checksum and footer, buffers payload.
// Depends on cpd_pkg; pushes descriptors into cpd_desc_fifo.
module cpd_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [cpd_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          cfg_wr,
  input  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpd_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          bank,
  output cpd_pkg::mem_wr_t              mem_wr,
  output logic                          desc_push,
  output cpd_pkg::desc_t                desc
);
  import cpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LENGTH, PH_TYPE_HI, PH_TYPE_LO, PH_DATA, PH_CHECK, PH_FOOTER
  } phase_t;

  phase_t             phase;
  logic [BYTE_W-1:0]  header_byte;
  logic [BYTE_W-1:0]  footer_byte;
  logic [LEN_W-1:0]   stored_length;
  logic [LEN_W-1:0]   byte_count;
  logic [LEN_W-1:0]   byte_count_next;
  logic [TYPE_W-1:0]  type_value;
  logic [BYTE_W-1:0]  running_sum;

  assign byte_count_next = byte_count + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      footer_byte <= FOOTER_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_HEADER) header_byte <= cfg_data;
      if (cfg_index == CFG_FOOTER) footer_byte <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      stored_length <= '0;
      byte_count    <= '0;
      type_value    <= '0;
      running_sum   <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_LENGTH: begin
          if (rx_byte < BYTE_W'(MAX_PAYLOAD)) begin
            stored_length <= rx_byte[LEN_W-1:0];
            byte_count    <= '0;
            type_value    <= '0;
            running_sum   <= header_byte + rx_byte;
            phase         <= PH_TYPE_HI;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_TYPE_HI: begin
          running_sum <= running_sum + rx_byte;
          type_value  <= TYPE_W'(rx_byte);
          phase       <= PH_TYPE_LO;
        end
        PH_TYPE_LO: begin
          running_sum <= running_sum + rx_byte;
          type_value  <= {type_value[BYTE_W-1:0], rx_byte};
          phase       <= (stored_length != '0) ? PH_DATA : PH_CHECK;
        end
        PH_DATA: begin
          running_sum <= running_sum + rx_byte;
          byte_count  <= byte_count_next;
          if (byte_count_next == stored_length) phase <= PH_CHECK;
        end
        PH_CHECK: begin
          phase <= (rx_byte == running_sum) ? PH_FOOTER : PH_HUNT;
        end
        PH_FOOTER: begin
          phase <= PH_HUNT;
        end
        default: begin
          phase <= (rx_byte == header_byte) ? PH_LENGTH : PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    mem_wr.en   = accept && (phase == PH_DATA);
    mem_wr.bank = bank;
    mem_wr.idx  = byte_count;
    mem_wr.data = rx_byte;
  end

  // Emit the packet on a matching footer; a bad footer drops it.
  assign desc_push  = accept && (phase == PH_FOOTER) && (rx_byte == footer_byte);
  assign desc.ptype = type_value;
  assign desc.len   = stored_length;
  assign desc.bank  = bank;

endmodule

/* rtl/cpd_desc_fifo.sv */
// Two-entry descriptor queue between parser and drain.
// Depends on cpd_pkg; the write slot doubles as the payload bank.
module cpd_desc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpd_pkg::desc_t din,
  input  logic           pop,
  output cpd_pkg::desc_t dout,
  output logic           valid,
  output logic           full,
  output logic           wr_slot
);
  import cpd_pkg::*;

  desc_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  assign dout    = slots[rd_ptr];
  assign valid   = (count != '0);
  assign full    = (count == 2'd2);
  assign wr_slot = wr_ptr;

endmodule

/* rtl/cpd_back.sv */
// Drain: holds the two-bank payload buffer and plays packets out as results.
// Depends on cpd_pkg; reads descriptors from cpd_desc_fifo.
module cpd_back #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cpd_pkg::mem_wr_t            mem_wr,
  input  cpd_pkg::desc_t              desc,
  input  logic                        desc_valid,
  output logic                        desc_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [cpd_pkg::TYPE_W-1:0]  packet_type,
  output logic [cpd_pkg::LEN_W-1:0]   payload_length,
  output logic [cpd_pkg::LEN_W-1:0]   byte_index,
  output logic [cpd_pkg::BYTE_W-1:0]  payload_byte,
  output logic                        empty_packet,
  output logic                        last
);
  import cpd_pkg::*;

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int DEPTH = 2 << IDX_W;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_q;

  logic              out_valid;
  logic              rd_pend;
  logic [LEN_W-1:0]  idx;
  logic [TYPE_W-1:0] meta_type;
  logic [LEN_W-1:0]  meta_len;
  logic [LEN_W-1:0]  meta_idx;
  logic              meta_last;

  logic              pop_ok;
  logic              issue;
  logic              issue_rd;
  logic              idx_last;

  assign pop_ok   = pop && out_valid;
  // Start the next word only when the output register is free by the time it lands.
  assign issue    = desc_valid && !rd_pend && (!out_valid || pop_ok);
  assign issue_rd = issue && (desc.len != '0);
  assign idx_last = (idx == desc.len - LEN_W'(1));
  assign desc_pop = issue && ((desc.len == '0) || idx_last);

  always_ff @(posedge clk) begin
    if (mem_wr.en) mem[{mem_wr.bank, mem_wr.idx[IDX_W-1:0]}] <= mem_wr.data;
  end

  always_ff @(posedge clk) begin
    if (issue_rd) begin
      mem_q     <= mem[{desc.bank, idx[IDX_W-1:0]}];
      meta_type <= desc.ptype;
      meta_len  <= desc.len;
      meta_idx  <= idx;
      meta_last <= idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      idx       <= '0;
    end else begin
      rd_pend <= issue_rd;
      if (issue_rd) idx <= idx_last ? '0 : idx + LEN_W'(1);
      priority if (rd_pend) begin
        out_valid      <= 1'b1;
        packet_type    <= meta_type;
        payload_length <= meta_len;
        byte_index     <= meta_idx;
        payload_byte   <= mem_q;
        empty_packet   <= 1'b0;
        last           <= meta_last;
      end else if (issue && !issue_rd) begin
        out_valid      <= 1'b1;
        packet_type    <= desc.ptype;
        payload_length <= '0;
        byte_index     <= '0;
        payload_byte   <= '0;
        empty_packet   <= 1'b1;
        last           <= 1'b1;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end else begin
        // hold the current word
      end
    end
  end

  assign empty = !out_valid;

endmodule

/* rtl/checksummed_packet_deframer_core.sv */
// The block takes one received byte per cycle whenever full is low and emits one result
// per payload byte of each packet whose checksum and footer check out (one result for an
// empty packet). Input stalls (full high) only while two accepted packets still await
// delivery, since the payload buffer has two banks. Each payload result passes through the
// registered payload buffer read and then the output register load, and no new read starts
// while one is pending; an empty-packet result loads the output register directly.
// Depends on cpd_pkg, cpd_front, cpd_desc_fifo and cpd_back.
module checksummed_packet_deframer_core #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [cpd_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpd_pkg::BYTE_W-1:0]    cfg_data,
  output logic                          empty,
  input  logic                          pop,
  output logic [cpd_pkg::TYPE_W-1:0]    packet_type,
  output logic [cpd_pkg::LEN_W-1:0]     payload_length,
  output logic [cpd_pkg::LEN_W-1:0]     byte_index,
  output logic [cpd_pkg::BYTE_W-1:0]    payload_byte,
  output logic                          empty_packet,
  output logic                          last
);
  import cpd_pkg::*;

  logic    accept;
  logic    desc_push;
  logic    desc_pop;
  logic    desc_valid;
  logic    wr_slot;
  desc_t   desc_in;
  desc_t   desc_out;
  mem_wr_t mem_wr;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  cpd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bank      (wr_slot),
    .mem_wr    (mem_wr),
    .desc_push (desc_push),
    .desc      (desc_in)
  );

  cpd_desc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (desc_push),
    .din     (desc_in),
    .pop     (desc_pop),
    .dout    (desc_out),
    .valid   (desc_valid),
    .full    (full),
    .wr_slot (wr_slot)
  );

  cpd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk            (clk),
    .rst            (rst),
    .mem_wr         (mem_wr),
    .desc           (desc_out),
    .desc_valid     (desc_valid),
    .desc_pop       (desc_pop),
    .pop            (pop),
    .empty          (empty),
    .packet_type    (packet_type),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .empty_packet   (empty_packet),
    .last           (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> !full)
    else $error("descriptor pushed into a full queue");

  a_no_bank_write_when_full: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> !full)
    else $error("payload written into a bank still pending");

  a_empty_packet_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_packet) |-> (last && byte_index == '0 && payload_byte == '0))
    else $error("malformed empty-packet word");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && !empty_packet && last) |-> (byte_index == payload_length - LEN_W'(1)))
    else $error("last flag on wrong payload index");

endmodule
